@@ sv/deque_with_remove_by_value_assert.svh @@
// Assertion macros for the bounded deque.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef DEQUE_WITH_REMOVE_BY_VALUE_ASSERT_SVH
`define DEQUE_WITH_REMOVE_BY_VALUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dwrbv_pkg.sv @@
// Shared types and constants for the bounded deque with delete by value.
// No dependencies.
package dwrbv_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 5;

  typedef enum logic [1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_BACK  = 2'd1,
    FN_DELETE     = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic               push_front;
    logic               push_back;
    logic               remove;
    logic [VALUE_W-1:0] item;
  } cell_ctl_t;

endpackage

@@ sv/deque_with_remove_by_value.sv @@
// Bounded deque of signed 32-bit values with delete of the first matching entry.
// Usage: raise start for one cycle with func and item_value while busy is low;
// the request is taken at that clock edge. func 0 inserts at the front, 1 at
// the back, 2 deletes the first entry from the front equal to item_value.
// Every request yields one result: done rises at the edge after the request
// edge and stays high for exactly one cycle with status, entry_count,
// front_value and back_value, so the result is taken while done is high.
// The receiver cannot stall; results must be taken as shown.
// Throughput is one request per cycle while busy is low: the row of cells
// compares every entry and shifts in the cycle of the request, and a second
// register stage picks the front and back entries from the updated row.
// Busy is high during reset and until the first clock edge after reset is
// released. Reset empties the list and drops any result in flight; cell
// contents are not cleared.
// Depends on dwrbv_pkg, dwrbv_cell and deque_with_remove_by_value_assert.svh.
`include "deque_with_remove_by_value_assert.svh"

module deque_with_remove_by_value
  import dwrbv_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                func,
  input  logic signed [VALUE_W-1:0] item_value,
  output logic                      done,
  output logic [1:0]                status,
  output logic [COUNT_W-1:0]        entry_count,
  output logic signed [VALUE_W-1:0] front_value,
  output logic signed [VALUE_W-1:0] back_value
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic                accept;
  logic                full;
  logic                empty;
  func_t               fn;
  cell_ctl_t           ctl;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [VALUE_W-1:0]  cell_value [CAPACITY];
  logic [CAPACITY:0]   found;
  logic                found_all;
  status_t             op_status;
  logic                pend;
  status_t             pend_status;
  logic [VALUE_W-1:0]  back_sel;
  logic [CW+COUNT_W-1:0] count_ext;

  assign accept    = start && !busy;
  assign full      = count == CAP_C;
  assign empty     = count == '0;
  assign fn        = func_t'(func);
  assign found[0]  = 1'b0;
  assign found_all = found[CAPACITY];

  always_comb begin
    ctl.push_front = accept && (fn == FN_PUSH_FRONT) && !full;
    ctl.push_back  = accept && (fn == FN_PUSH_BACK) && !full;
    ctl.remove     = accept && (fn == FN_DELETE);
    ctl.item       = item_value;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dwrbv_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .left_value  ((i == 0) ? ctl.item : cell_value[(i == 0) ? 0 : i - 1]),
      .right_value (cell_value[(i == CAPACITY - 1) ? i : i + 1]),
      .found_in    (found[i]),
      .found_out   (found[i+1]),
      .value       (cell_value[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctl.push_front || ctl.push_back) begin
      count_next = count + 1'b1;
    end else if (ctl.remove && found_all) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    case (fn)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        op_status = full ? ST_FULL : ST_OK;
      end
      FN_DELETE: begin
        if (empty) begin
          op_status = ST_EMPTY;
        end else begin
          op_status = found_all ? ST_OK : ST_NOT_FOUND;
        end
      end
      default: begin
        op_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    back_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if ((CW + 1)'(i + 1) == {1'b0, count}) begin
        back_sel = back_sel | cell_value[i];
      end
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b1;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      busy  <= 1'b0;
      pend  <= accept;
      done  <= pend;
    end
  end

  always_ff @(posedge clk) begin
    pend_status <= op_status;
    status      <= pend_status;
    entry_count <= count_ext[COUNT_W-1:0];
    front_value <= empty ? '0 : cell_value[0];
    back_value  <= empty ? '0 : back_sel;
  end

  `DQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CAP_C, "count above capacity")
  `DQ_ASSERT_NEXT(a_result_follows, pend, done, "request produced no result")
  `DQ_ASSERT_NOW(a_full_status, pend && (pend_status == ST_FULL), count == CAP_C,
                 "full status while list not full")
  `DQ_ASSERT_NEXT(a_delete_count, ctl.remove && found_all,
                  count == CW'($past(count) - 1'b1), "delete did not shrink count")

endmodule

@@ sv/dwrbv_cell.sv @@
// One storage cell of the deque chain: holds one entry and shifts with its neighbors.
// Depends on dwrbv_pkg.
module dwrbv_cell
  import dwrbv_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [CW-1:0]      count,
  input  logic [VALUE_W-1:0] left_value,
  input  logic [VALUE_W-1:0] right_value,
  input  logic               found_in,
  output logic               found_out,
  output logic [VALUE_W-1:0] value
);

  localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
  localparam logic [CW:0]   NEXT_IDX = (CW + 1)'(IDX + 1);

  logic               valid;
  logic               match;
  logic               shift_in;
  logic [VALUE_W-1:0] value_next;

  assign valid     = MY_IDX < count;
  assign match     = valid && (value == ctl.item);
  assign found_out = found_in | match;
  assign shift_in  = found_out && (NEXT_IDX < {1'b0, count});

  always_comb begin
    value_next = value;
    if (ctl.push_front) begin
      value_next = left_value;
    end else if (ctl.push_back && (MY_IDX == count)) begin
      value_next = ctl.item;
    end else if (ctl.remove && shift_in) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for deque_with_remove_by_value: directed and random requests
// with a scoreboard class that mirrors the list and checks every result in order.
// Depends on dwrbv_pkg and the deque_with_remove_by_value RTL.
module tb;
  import dwrbv_pkg::*;

  // The selector code that the package leaves unused; the block treats it as no operation.
  localparam logic [1:0] FN_NOP = 2'd3;
  localparam int MAX_CYCLES = 200000;

  typedef struct {
    status_t                   status;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] front;
    logic signed [VALUE_W-1:0] back;
  } outcome_t;

  class deque_mirror;
    logic signed [VALUE_W-1:0] entries[$];
    outcome_t pending_outcomes[$];
    int errors;
    int checked;
    int requests;
    int status_seen[4];

    function new();
      errors = 0;
      checked = 0;
      requests = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int size();
      return entries.size();
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function logic signed [VALUE_W-1:0] pick_present();
      return entries[$urandom_range(0, entries.size() - 1)];
    endfunction

    function void note_request(logic [1:0] f, logic signed [VALUE_W-1:0] v);
      outcome_t o;
      int hit;
      o.status = ST_OK;
      hit = -1;
      case (f)
        FN_PUSH_FRONT, FN_PUSH_BACK: begin
          if (entries.size() >= DEF_CAPACITY) o.status = ST_FULL;
          else if (f == FN_PUSH_FRONT) entries.push_front(v);
          else entries.push_back(v);
        end
        FN_DELETE: begin
          if (entries.size() == 0) begin
            o.status = ST_EMPTY;
          end else begin
            for (int i = 0; i < entries.size() && hit < 0; i++)
              if (entries[i] == v) hit = i;
            if (hit < 0) o.status = ST_NOT_FOUND;
            else entries.delete(hit);
          end
        end
        default: ;
      endcase
      o.count = COUNT_W'(entries.size());
      o.front = (entries.size() == 0) ? '0 : entries[0];
      o.back  = (entries.size() == 0) ? '0 : entries[$];
      pending_outcomes.push_back(o);
      requests++;
    endfunction

    function void report(string field, logic signed [VALUE_W-1:0] want,
                         logic signed [VALUE_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_outcome(logic [1:0] s, logic [COUNT_W-1:0] c,
                                logic signed [VALUE_W-1:0] fv,
                                logic signed [VALUE_W-1:0] bv);
      outcome_t o;
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, status %0d count %0d",
                 $time, s, c);
        return;
      end
      o = pending_outcomes.pop_front();
      checked++;
      status_seen[o.status]++;
      if (s !== o.status) report("status", o.status, s);
      if (c !== o.count) report("entry_count", o.count, c);
      if (fv !== o.front) report("front_value", o.front, fv);
      if (bv !== o.back) report("back_value", o.back, bv);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] func;
  logic signed [VALUE_W-1:0] item_value;
  logic done;
  logic [1:0] status;
  logic [COUNT_W-1:0] entry_count;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] back_value;

  deque_mirror book = new();
  bit growing = 1;
  int cycles = 0;

  deque_with_remove_by_value u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .item_value(item_value),
    .done(done),
    .status(status),
    .entry_count(entry_count),
    .front_value(front_value),
    .back_value(back_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results pending", cycles, book.pending());
      $display("deque_with_remove_by_value verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) book.check_outcome(status, entry_count, front_value, back_value);
  end

  task automatic issue(logic [1:0] f, logic signed [VALUE_W-1:0] v);
    @(negedge clk);
    start <= 1'b1;
    func <= f;
    item_value <= v;
    do @(posedge clk); while (busy);
    book.note_request(f, v);
  endtask

  task automatic maybe_idle(int pct);
    int n;
    if ($urandom_range(0, 99) < pct) begin
      n = $urandom_range(1, 4);
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4) - 2;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    int roll;
    int n;
    int push_pct;
    logic [1:0] f;
    logic signed [VALUE_W-1:0] v;
    roll = $urandom_range(0, 99);
    n = book.size();
    if (n == DEF_CAPACITY) growing = 0;
    else if (n == 0) growing = 1;
    push_pct = growing ? 70 : 30;
    v = pick_value();
    if (roll < 3) begin
      f = FN_NOP;
    end else if (roll < 3 + push_pct) begin
      f = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
    end else begin
      f = FN_DELETE;
      if (n > 0 && $urandom_range(0, 3) != 0) v = book.pick_present();
    end
    issue(f, v);
  endtask

  initial begin
    int idle_pct[4];
    rst = 1'b1;
    start = 1'b0;
    func = FN_PUSH_FRONT;
    item_value = '0;
    idle_pct = '{0, 48, 0, 23};
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    issue(FN_DELETE, 32'sd7);
    issue(FN_NOP, 32'sd0);
    issue(FN_PUSH_BACK, 32'sh7fffffff);
    issue(FN_PUSH_FRONT, 32'sh80000000);
    issue(FN_PUSH_BACK, 32'sd0);
    issue(FN_PUSH_BACK, -32'sd1);
    issue(FN_PUSH_FRONT, 32'sd1);
    issue(FN_PUSH_BACK, 32'sd5);
    issue(FN_PUSH_FRONT, 32'sd5);
    issue(FN_DELETE, 32'sd12345);
    issue(FN_DELETE, 32'sd5);
    issue(FN_DELETE, 32'sd0);
    issue(FN_NOP, -32'sd1);
    while (book.size() < DEF_CAPACITY) issue(FN_PUSH_BACK, $urandom);
    issue(FN_PUSH_FRONT, 32'sd9);
    issue(FN_PUSH_BACK, 32'sd9);
    drain();

    foreach (idle_pct[p]) begin
      for (int i = 0; i < 225; i++) begin
        random_request();
        maybe_idle(idle_pct[p]);
      end
      // Let the pipeline run dry before the next phase.
      drain();
    end

    $display("Checked %0d results for %0d requests: %0d ok, %0d not found, %0d empty, %0d full.",
             book.checked, book.requests, book.status_seen[ST_OK],
             book.status_seen[ST_NOT_FOUND], book.status_seen[ST_EMPTY],
             book.status_seen[ST_FULL]);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("deque_with_remove_by_value verification clean");
    end else begin
      $display("%0d errors, %0d results never arrived", book.errors, book.pending());
      $display("deque_with_remove_by_value verification failed");
    end
    $finish;
  end

endmodule

@@ deque_with_remove_by_value.f @@
+incdir+sv
sv/dwrbv_pkg.sv
sv/dwrbv_cell.sv
sv/deque_with_remove_by_value.sv
tb/sv/tb.sv
